// File: hw/rtl/scan_frame_crop_lut_flip_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scan frame reformatter
// Shorthand for the concurrent checks used in the RTL. Every check is sampled
// on clk_i and is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SCAN_FRAME_CROP_LUT_FLIP_UNIT_MACROS_SVH
`define SCAN_FRAME_CROP_LUT_FLIP_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define SFCLF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SFCLF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SFCLF_ASSERT_IMP(lbl, ante, cons, msg)
`define SFCLF_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// File: hw/rtl/sfclf_pkg.sv
// ----------------------------------------------------------------------------
// Scan frame reformatter package
// Shared widths, register indexes, reset values and the structs that pass
// configuration and raster position between the modules.
// ----------------------------------------------------------------------------
package sfclf_pkg;

  // Channel and lookup table geometry.
  localparam int CHANNELS    = 4;
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EN_W        = 4;
  localparam int TABLE_BITS  = 14;
  localparam int TABLE_SIZE  = 2 ** TABLE_BITS;
  localparam int MEM_AW      = CH_W + TABLE_BITS;
  localparam int MEM_DEPTH   = 2 ** MEM_AW;

  // Field widths.
  localparam int SAMPLE_W    = 16;
  localparam int VALUE_W     = 16;
  localparam int ADDR_W      = 22;
  localparam int DIM_W       = 11;
  localparam int POS_W       = 10;
  localparam int SKIP_W      = 10;
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int ROWB_W      = $clog2(MAX_WIDTH * MAX_HEIGHT);

  // Stream payload widths.
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 40;

  // Configuration port.
  localparam int APB_AW      = 5;
  localparam int APB_DW      = 32;

  // Register indexes (byte address divided by four).
  typedef enum logic [2:0] {
    REG_CHANNEL_ENABLE  = 3'd0,
    REG_FRAME_WIDTH     = 3'd1,
    REG_FRAME_HEIGHT    = 3'd2,
    REG_SKIP_TOP        = 3'd3,
    REG_SKIP_BOTTOM     = 3'd4,
    REG_FLYBACK_IMAGING = 3'd5
  } reg_idx_e;

  // Input beat kinds carried on tuser.
  typedef enum logic {
    ACT_TABLE_WRITE = 1'b0,
    ACT_SAMPLE      = 1'b1
  } action_e;

  // Register reset values.
  localparam logic [EN_W-1:0]   RST_ENABLE  = 4'h1;
  localparam logic [DIM_W-1:0]  RST_WIDTH   = 11'd512;
  localparam logic [DIM_W-1:0]  RST_HEIGHT  = 11'd512;
  localparam logic [SKIP_W-1:0] RST_SKIP    = '0;
  localparam logic [ADDR_W-1:0] RST_CROPPED = ADDR_W'(512 * 512);

  // Scan configuration as seen by the raster counters.
  typedef struct packed {
    logic [EN_W-1:0]   enable;
    logic              any_en;
    logic [CH_W-1:0]   first_ch;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [SKIP_W-1:0] skip_top;
    logic [DIM_W-1:0]  keep_hi;
    logic [ADDR_W-1:0] cropped;
    logic [ROWB_W-1:0] rev_start;
    logic              flyback;
    logic              restart;
  } scan_cfg_t;

  // Raster position of the sample now in the input stage.
  typedef struct packed {
    logic              keep;
    logic [ADDR_W-1:0] addr;
    logic [CH_W-1:0]   chan;
  } scan_pos_t;

  // Zero acts as one, values above the maximum saturate.
  function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] v,
                                                input logic [DIM_W-1:0] vmax);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > vmax) begin
      r = vmax;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/sfclf_cfg.sv
// ----------------------------------------------------------------------------
// Scan frame reformatter configuration registers
// APB register file plus registered values derived from it: effective frame
// size, kept line band, cropped frame size and the scan restart strobe.
// ----------------------------------------------------------------------------
module sfclf_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sfclf_pkg::APB_AW-1:0] paddr,
  input  logic [sfclf_pkg::APB_DW-1:0] pwdata,
  output logic [sfclf_pkg::APB_DW-1:0] prdata,
  output logic                      pready,
  output sfclf_pkg::scan_cfg_t      cfg_o
);
  import sfclf_pkg::*;

  logic [EN_W-1:0]   enable_q;
  logic [DIM_W-1:0]  width_q, height_q;
  logic [SKIP_W-1:0] skip_top_q, skip_bot_q;
  logic              flyback_q;
  logic              restart_q, restart_d;

  logic [DIM_W-1:0]  w_eff_d, w_eff_q, h_eff_d, h_eff_q;
  logic [DIM_W-1:0]  band, kept, keep_hi_d, keep_hi_q;
  logic [2*DIM_W-1:0] prod;
  logic [ADDR_W-1:0] cropped_q;
  logic              any_en;
  logic [CH_W-1:0]   first_ch;

  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[APB_AW-1:2]);

  // Register writes; a write to a defined register restarts the scan.
  always_comb begin
    restart_d = 1'b0;
    if (wr_en) begin
      case (idx)
        REG_CHANNEL_ENABLE, REG_FRAME_WIDTH, REG_FRAME_HEIGHT,
        REG_SKIP_TOP, REG_SKIP_BOTTOM, REG_FLYBACK_IMAGING: restart_d = 1'b1;
        default: restart_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= RST_ENABLE;
      width_q    <= RST_WIDTH;
      height_q   <= RST_HEIGHT;
      skip_top_q <= RST_SKIP;
      skip_bot_q <= RST_SKIP;
      flyback_q  <= 1'b0;
      restart_q  <= 1'b0;
    end else begin
      restart_q <= restart_d;
      if (wr_en) begin
        case (idx)
          REG_CHANNEL_ENABLE:  enable_q   <= pwdata[EN_W-1:0];
          REG_FRAME_WIDTH:     width_q    <= pwdata[DIM_W-1:0];
          REG_FRAME_HEIGHT:    height_q   <= pwdata[DIM_W-1:0];
          REG_SKIP_TOP:        skip_top_q <= pwdata[SKIP_W-1:0];
          REG_SKIP_BOTTOM:     skip_bot_q <= pwdata[SKIP_W-1:0];
          REG_FLYBACK_IMAGING: flyback_q  <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  // Read-back of the raw register values.
  always_comb begin
    prdata = '0;
    case (idx)
      REG_CHANNEL_ENABLE:  prdata = APB_DW'(enable_q);
      REG_FRAME_WIDTH:     prdata = APB_DW'(width_q);
      REG_FRAME_HEIGHT:    prdata = APB_DW'(height_q);
      REG_SKIP_TOP:        prdata = APB_DW'(skip_top_q);
      REG_SKIP_BOTTOM:     prdata = APB_DW'(skip_bot_q);
      REG_FLYBACK_IMAGING: prdata = APB_DW'(flyback_q);
      default:             prdata = '0;
    endcase
  end

  // Effective frame size and the band of kept lines.
  always_comb begin
    w_eff_d = eff_size(width_q, DIM_W'(MAX_WIDTH));
    h_eff_d = eff_size(height_q, DIM_W'(MAX_HEIGHT));
    band    = DIM_W'(skip_top_q) + DIM_W'(skip_bot_q);
    kept    = (band < h_eff_d) ? (h_eff_d - band) : '0;
    keep_hi_d = (kept == '0) ? '0 : (DIM_W'(skip_top_q) + kept);
    prod    = kept * w_eff_d;
  end

  // Lowest enabled channel.
  always_comb begin
    any_en   = 1'b0;
    first_ch = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (i < EN_W && enable_q[i]) begin
        any_en   = 1'b1;
        first_ch = CH_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_eff_q   <= RST_WIDTH;
      h_eff_q   <= RST_HEIGHT;
      keep_hi_q <= RST_HEIGHT;
      cropped_q <= RST_CROPPED;
    end else begin
      w_eff_q   <= w_eff_d;
      h_eff_q   <= h_eff_d;
      keep_hi_q <= keep_hi_d;
      cropped_q <= ADDR_W'(prod);
    end
  end

  assign cfg_o.enable    = enable_q;
  assign cfg_o.any_en    = any_en;
  assign cfg_o.first_ch  = first_ch;
  assign cfg_o.width     = w_eff_q;
  assign cfg_o.height    = h_eff_q;
  assign cfg_o.skip_top  = skip_top_q;
  assign cfg_o.keep_hi   = keep_hi_q;
  assign cfg_o.cropped   = cropped_q;
  assign cfg_o.rev_start = ROWB_W'(cropped_q - ADDR_W'(w_eff_q));
  assign cfg_o.flyback   = flyback_q;
  assign cfg_o.restart   = restart_q;

endmodule

// File: hw/rtl/sfclf_scan.sv
// ----------------------------------------------------------------------------
// Scan frame reformatter raster counters
// Tracks column, row, channel, channel rank and frame-set reversal, and keeps
// running row and rank base offsets, summed with the column for the address.
// ----------------------------------------------------------------------------
`include "scan_frame_crop_lut_flip_unit_macros.svh"

module sfclf_scan (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sfclf_pkg::scan_cfg_t cfg_i,
  input  logic                 step_i,
  output sfclf_pkg::scan_pos_t pos_o
);
  import sfclf_pkg::*;

  logic [POS_W-1:0]  col_q;
  logic [POS_W-1:0]  row_q;
  logic [CH_W-1:0]   chan_q;
  logic [CH_W-1:0]   rank_q;
  logic              rev_q;
  logic [ROWB_W-1:0] row_base_q;
  logic [ADDR_W-1:0] rank_base_q;

  logic [DIM_W-1:0]  col_w, row_w;
  logic              col_end, row_end, keep;
  logic              nxt_found, rev_next;
  logic [CH_W-1:0]   nxt_ch;

  assign col_w   = DIM_W'(col_q);
  assign row_w   = DIM_W'(row_q);
  assign col_end = (col_w + DIM_W'(1)) >= cfg_i.width;
  assign row_end = (row_w + DIM_W'(1)) >= cfg_i.height;
  assign keep    = cfg_i.any_en && (row_w >= DIM_W'(cfg_i.skip_top))
                   && (row_w < cfg_i.keep_hi);

  // Next enabled channel above the current one, if any.
  always_comb begin
    nxt_found = 1'b0;
    nxt_ch    = cfg_i.first_ch;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (i < EN_W && i > int'(chan_q) && cfg_i.enable[i]) begin
        nxt_found = 1'b1;
        nxt_ch    = CH_W'(i);
      end
    end
  end

  // Reversal flag of the frame that follows the current one.
  assign rev_next = nxt_found ? rev_q : (cfg_i.flyback && !rev_q);

  // Raster advance, one sample per step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      chan_q      <= '0;
      rank_q      <= '0;
      rev_q       <= 1'b0;
      row_base_q  <= '0;
      rank_base_q <= '0;
    end else if (cfg_i.restart) begin
      col_q       <= '0;
      row_q       <= '0;
      chan_q      <= cfg_i.first_ch;
      rank_q      <= '0;
      rev_q       <= 1'b0;
      row_base_q  <= '0;
      rank_base_q <= '0;
    end else if (step_i) begin
      if (!col_end) begin
        col_q <= col_q + POS_W'(1);
      end else begin
        col_q <= '0;
        if (row_end) begin
          // End of frame: move to the next channel or wrap the frame set.
          row_q      <= '0;
          row_base_q <= rev_next ? cfg_i.rev_start : '0;
          rev_q      <= rev_next;
          chan_q     <= nxt_ch;
          if (nxt_found) begin
            rank_q      <= rank_q + CH_W'(1);
            rank_base_q <= rank_base_q + cfg_i.cropped;
          end else begin
            rank_q      <= '0;
            rank_base_q <= '0;
          end
        end else begin
          row_q <= row_q + POS_W'(1);
          if (keep) begin
            if (rev_q) begin
              row_base_q <= row_base_q - ROWB_W'(cfg_i.width);
            end else begin
              row_base_q <= row_base_q + ROWB_W'(cfg_i.width);
            end
          end
        end
      end
    end
  end

  assign pos_o.keep = keep;
  assign pos_o.addr = rank_base_q + ADDR_W'(row_base_q) + ADDR_W'(col_q);
  assign pos_o.chan = chan_q;

  `SFCLF_ASSERT_IMP(a_col_in_line, 1'b1, col_w < cfg_i.width, "column beyond line width")
  `SFCLF_ASSERT_IMP(a_row_in_frame, 1'b1, row_w < cfg_i.height, "row beyond frame height")
  `SFCLF_ASSERT_IMP(a_rank_base_zero, rank_q == '0, rank_base_q == '0, "rank base out of step")

endmodule

// File: hw/rtl/sfclf_lut.sv
// ----------------------------------------------------------------------------
// Scan frame reformatter lookup table memory
// One table per channel in a single RAM: one write port and one read port
// with registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module sfclf_lut (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [sfclf_pkg::MEM_AW-1:0]  wr_addr_i,
  input  logic [sfclf_pkg::VALUE_W-1:0] wr_data_i,
  input  logic                          rd_en_i,
  input  logic [sfclf_pkg::MEM_AW-1:0]  rd_addr_i,
  output logic [sfclf_pkg::VALUE_W-1:0] rd_data_o
);
  import sfclf_pkg::*;

  logic [VALUE_W-1:0] lut_mem_q [MEM_DEPTH];
  logic [VALUE_W-1:0] rd_data_q;

  // Table entry load.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      lut_mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered lookup.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= lut_mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hw/rtl/scan_frame_crop_lut_flip_unit.sv
// ----------------------------------------------------------------------------
// Scan frame reformatter top level
// Accepts one beat per clock cycle and presents each kept sample on the
// result stream through the output register. An input register captures
// the beat. While it is held there, the raster counters decide whether the
// line is kept and form the buffer address; as it moves on, the lookup RAM
// is either written (table load) or read (kept sample). The RAM's registered
// read port and the output register form the second stage. Throughput is one
// beat per cycle, because each beat uses only one of the lookup RAM's two
// ports. Back-pressure on the result stream stalls the input only once both
// stages are full. The lookup tables are not cleared at reset.
// ----------------------------------------------------------------------------
module scan_frame_crop_lut_flip_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input beats
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // sample[15:0], table_channel[17:16], table_index[31:18], table_value[47:32]
  input  logic [sfclf_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // action[0]
  input  logic                             s_axis_tuser_i,
  // Result beats
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // pixel_address[21:0], pixel_value[37:22], source_channel[39:38]
  output logic [sfclf_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // Configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sfclf_pkg::APB_AW-1:0]     paddr,
  input  logic [sfclf_pkg::APB_DW-1:0]     pwdata,
  output logic [sfclf_pkg::APB_DW-1:0]     prdata,
  output logic                             pready
);
  import sfclf_pkg::*;

  scan_cfg_t cfg;
  scan_pos_t pos;

  // Input stage.
  logic                 s1_valid_q;
  action_e              s1_action_q;
  logic [IN_DATA_W-1:0] s1_data_q;

  // Output stage.
  logic                 s2_valid_q, s2_valid_d;
  logic [ADDR_W-1:0]    s2_addr_q;
  logic [CH_W-1:0]      s2_chan_q;
  logic                 s2_neg_q;

  logic                        out_free, s1_go, is_sample, step, produce;
  logic signed [SAMPLE_W-1:0]  smp;
  logic [CH_W-1:0]             tbl_ch;
  logic [TABLE_BITS-1:0]       tbl_idx, rd_idx;
  logic [VALUE_W-1:0]          tbl_val, rd_data, pix_val;
  logic                        sat;

  sfclf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Stage handshakes.
  assign out_free        = !s2_valid_q || m_axis_tready_i;
  assign s1_go           = s1_valid_q && out_free;
  assign s_axis_tready_o = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      s1_action_q <= action_e'(s_axis_tuser_i);
      s1_data_q   <= s_axis_tdata_i;
    end
  end

  // Input beat fields.
  assign smp     = s1_data_q[SAMPLE_W-1:0];
  assign tbl_ch  = s1_data_q[17:16];
  assign tbl_idx = s1_data_q[31:18];
  assign tbl_val = s1_data_q[47:32];

  assign is_sample = (s1_action_q == ACT_SAMPLE);
  assign step      = s1_go && is_sample && cfg.any_en;
  assign produce   = step && pos.keep;

  sfclf_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .pos_o  (pos)
  );

  // Samples beyond the table map through its last entry.
  assign sat    = {1'b0, smp} >= (SAMPLE_W + 1)'(TABLE_SIZE);
  assign rd_idx = sat ? '1 : smp[TABLE_BITS-1:0];

  sfclf_lut u_lut (
    .clk_i     (clk_i),
    .wr_en_i   (s1_go && !is_sample),
    .wr_addr_i ({tbl_ch, tbl_idx}),
    .wr_data_i (tbl_val),
    .rd_en_i   (produce),
    .rd_addr_i ({pos.chan, rd_idx}),
    .rd_data_o (rd_data)
  );

  // Output register.
  always_comb begin
    s2_valid_d = s2_valid_q;
    if (produce) begin
      s2_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      s2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      s2_addr_q <= pos.addr;
      s2_chan_q <= pos.chan;
      s2_neg_q  <= smp < 0;
    end
  end

  // Negative samples read as zero.
  assign pix_val         = s2_neg_q ? '0 : rd_data;
  assign m_axis_tvalid_o = s2_valid_q;
  assign m_axis_tdata_o  = {s2_chan_q, pix_val, s2_addr_q};

endmodule

// File: test/tb_scan_frame_crop_lut_flip_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the scan frame reformatter
// Streams table loads and raw samples into the block and predicts, for each
// accepted beat, the cropped, lookup-mapped and optionally row-reversed pixel
// it must produce. A checker pairs every result beat with the oldest
// prediction. Both stream sides idle at random, the result side holds off
// long enough once to back up the input, and the scan registers are
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_scan_frame_crop_lut_flip_unit;
  import sfclf_pkg::*;

  localparam int POOL_DEPTH    = 256;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_BEATS  = 650;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [VALUE_W-1:0] value;
    logic [CH_W-1:0]    chan;
  } pixel_t;

  // Clock and reset.
  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk_i = ~clk_i;

  // Stream and configuration signals.
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  s_tuser  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [APB_AW-1:0]     paddr    = '0;
  logic [APB_DW-1:0]     pwdata   = '0;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  scan_frame_crop_lut_flip_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Shadow of the scan registers.
  logic [EN_W-1:0]   cfg_enable      = RST_ENABLE;
  logic [DIM_W-1:0]  cfg_width       = RST_WIDTH;
  logic [DIM_W-1:0]  cfg_height      = RST_HEIGHT;
  logic [SKIP_W-1:0] cfg_skip_top    = RST_SKIP;
  logic [SKIP_W-1:0] cfg_skip_bottom = RST_SKIP;
  logic              cfg_flyback     = 1'b0;

  // Shadow of the raster position.
  int pos_col   = 0;
  int pos_row   = 0;
  int cur_ch    = 0;
  int cur_rank  = 0;
  bit rev_frame = 1'b0;

  // Shadow lookup tables and the entries known to be loaded.
  logic [VALUE_W-1:0] lut_mem     [CHANNELS][TABLE_SIZE];
  bit                 lut_written [CHANNELS][TABLE_SIZE];
  int                 known_idx   [CHANNELS][POOL_DEPTH];
  int                 known_cnt   [CHANNELS];

  pixel_t expected_pixels[$];
  int     mismatch_count = 0;
  int     beats_sent     = 0;

  // Idle controls shared with the result-side process.
  bit gaps_on     = 1'b1;
  bit stalls_on   = 1'b1;
  int hold_req    = 0;
  int hold_left   = 0;
  int stall_left  = 0;

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Zero acts as one, larger values saturate.
  function automatic int effective_dim(logic [DIM_W-1:0] v, int vmax);
    if (v == '0) return 1;
    if (int'(v) > vmax) return vmax;
    return int'(v);
  endfunction

  function automatic int lowest_enabled();
    for (int c = 0; c < CHANNELS; c++) begin
      if (cfg_enable[c]) return c;
    end
    return 0;
  endfunction

  // Unused fields of a beat carry random junk.
  function automatic logic [IN_DATA_W-1:0] pack_sample(logic [SAMPLE_W-1:0] s);
    return {16'($urandom), 14'($urandom), 2'($urandom), s};
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_table(logic [CH_W-1:0] ch,
                                                      logic [TABLE_BITS-1:0] ix,
                                                      logic [VALUE_W-1:0] val);
    return {val, ix, ch, 16'($urandom)};
  endfunction

  // A sample whose lookup only touches loaded entries of the current channel:
  // mostly in range, some negative, some above the table size.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r;
    logic [TABLE_BITS-1:0] ix;
    ix = TABLE_BITS'(known_idx[cur_ch][$urandom_range(0, known_cnt[cur_ch] - 1)]);
    r = $urandom_range(0, 99);
    if (r < 10) return {1'b1, 1'($urandom), ix};
    if (r < 20) return {2'b01, 14'($urandom)};
    return {2'b00, ix};
  endfunction

  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  // Work out the pixel an accepted beat produces and advance the raster.
  task automatic predict_pixel(action_e act, logic [IN_DATA_W-1:0] d);
    int w, h, st, sb, kept, out_row, ch, ix, nxt;
    logic [SAMPLE_W-1:0] raw;
    logic [VALUE_W-1:0] val;
    longint addr;
    pixel_t px;
    if (act == ACT_TABLE_WRITE) begin
      ch = d[17:16];
      ix = d[31:18];
      lut_mem[ch][ix] = d[47:32];
      if (!lut_written[ch][ix]) begin
        lut_written[ch][ix] = 1'b1;
        if (known_cnt[ch] < POOL_DEPTH) begin
          known_idx[ch][known_cnt[ch]] = ix;
          known_cnt[ch]++;
        end
      end
      return;
    end
    if (cfg_enable == '0) return;
    w = effective_dim(cfg_width, MAX_WIDTH);
    h = effective_dim(cfg_height, MAX_HEIGHT);
    st = cfg_skip_top;
    sb = cfg_skip_bottom;
    kept = (st + sb < h) ? h - st - sb : 0;
    if (kept != 0 && pos_row >= st && pos_row < st + kept) begin
      out_row = pos_row - st;
      if (rev_frame) out_row = kept - 1 - out_row;
      raw = d[SAMPLE_W-1:0];
      if (raw[SAMPLE_W-1]) begin
        val = '0;
      end else begin
        val = lut_mem[cur_ch][(int'(raw) >= TABLE_SIZE) ? TABLE_SIZE - 1 : int'(raw)];
      end
      addr = longint'(cur_rank) * kept * w + longint'(out_row) * w + pos_col;
      px.addr  = ADDR_W'(addr);
      px.value = val;
      px.chan  = CH_W'(cur_ch);
      expected_pixels.insert(expected_pixels.size(), px);
    end
    // Advance column, row, channel and frame set.
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= h) begin
        pos_row = 0;
        nxt = cur_ch + 1;
        while (nxt < CHANNELS && !cfg_enable[nxt]) nxt++;
        if (nxt < CHANNELS) begin
          cur_ch = nxt;
          cur_rank = (cur_rank + 1) & 7;
        end else begin
          cur_ch = lowest_enabled();
          cur_rank = 0;
          rev_frame = cfg_flyback && !rev_frame;
        end
      end
    end
  endtask

  // Offer one beat, wait for it to be taken, then predict its effect.
  task automatic send_beat(action_e act, logic [IN_DATA_W-1:0] d);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 99) < 25) gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tdata  <= d;
    s_tuser  <= act;
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_tready);
    predict_pixel(act, d);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_sample();
    send_beat(ACT_SAMPLE, pack_sample(pick_sample()));
  endtask

  task automatic send_table_write(logic [CH_W-1:0] ch, logic [TABLE_BITS-1:0] ix,
                                  logic [VALUE_W-1:0] val);
    send_beat(ACT_TABLE_WRITE, pack_table(ch, ix, val));
  endtask

  // Stop offering beats and let every pending result come out.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle. Any write restarts the scan.
  task automatic write_reg(reg_idx_e ri, logic [APB_DW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ri, 2'b00};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (ri)
      REG_CHANNEL_ENABLE:  cfg_enable      = v[EN_W-1:0];
      REG_FRAME_WIDTH:     cfg_width       = v[DIM_W-1:0];
      REG_FRAME_HEIGHT:    cfg_height      = v[DIM_W-1:0];
      REG_SKIP_TOP:        cfg_skip_top    = v[SKIP_W-1:0];
      REG_SKIP_BOTTOM:     cfg_skip_bottom = v[SKIP_W-1:0];
      REG_FLYBACK_IMAGING: cfg_flyback     = v[0];
      default: ;
    endcase
    pos_col   = 0;
    pos_row   = 0;
    cur_ch    = lowest_enabled();
    cur_rank  = 0;
    rev_frame = 1'b0;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // Return to idle before the next transfer.
    @(negedge clk_i);
  endtask

  task automatic read_reg(reg_idx_e ri, output logic [APB_DW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {ri, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    v = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    // Return to idle before the next transfer.
    @(negedge clk_i);
  endtask

  task automatic set_config(logic [EN_W-1:0] en, logic [DIM_W-1:0] w,
                            logic [DIM_W-1:0] h, logic [SKIP_W-1:0] st,
                            logic [SKIP_W-1:0] sb, logic fb);
    drain_results();
    write_reg(REG_CHANNEL_ENABLE, APB_DW'(en));
    write_reg(REG_FRAME_WIDTH, APB_DW'(w));
    write_reg(REG_FRAME_HEIGHT, APB_DW'(h));
    write_reg(REG_SKIP_TOP, APB_DW'(st));
    write_reg(REG_SKIP_BOTTOM, APB_DW'(sb));
    write_reg(REG_FLYBACK_IMAGING, APB_DW'(fb));
  endtask

  // Load a few entries in every table, then stream with the reset settings.
  task automatic test_reset_defaults();
    for (int ch = 0; ch < CHANNELS; ch++) begin
      send_table_write(CH_W'(ch), '0, 16'h0000);
      send_table_write(CH_W'(ch), TABLE_BITS'(1), 16'hFFFF);
      send_table_write(CH_W'(ch), TABLE_BITS'(TABLE_SIZE - 1), 16'($urandom));
      send_table_write(CH_W'(ch), TABLE_BITS'(TABLE_SIZE / 2 - 1), 16'($urandom));
      repeat (4) send_table_write(CH_W'(ch), TABLE_BITS'($urandom), 16'($urandom));
    end
    repeat (8) send_sample();
  endtask

  // Degenerate sizes, no channel, full skip bands and sample extremes.
  task automatic test_directed_cases();
    logic [SAMPLE_W-1:0] extremes [8];
    extremes = '{16'h0000, 16'h0001, 16'h3FFF, 16'h4000,
                 16'h7FFF, 16'h8000, 16'hFFFF, 16'hC001};
    // Zero width and height act as one, so each sample is a whole frame.
    set_config(4'b0011, '0, '0, '0, '0, 1'b1);
    repeat (4) send_sample();
    // With no channel enabled every sample is ignored.
    set_config(4'b0000, 11'd4, 11'd4, '0, '0, 1'b0);
    repeat (3) send_sample();
    // Skip bands that cover the frame drop every line.
    set_config(4'b1111, 11'd2, 11'd2, 10'd1023, 10'd1023, 1'b1);
    repeat (4) send_sample();
    // Negative, large and boundary samples.
    set_config(4'b0001, 11'd4, 11'd2, '0, '0, 1'b0);
    foreach (extremes[i]) send_beat(ACT_SAMPLE, pack_sample(extremes[i]));
  endtask

  // Cropped frames from three channels, row reversal on every second set.
  task automatic test_flyback_sets();
    set_config(4'b1011, 11'd3, 11'd4, 10'd1, 10'd1, 1'b1);
    repeat (20) send_sample();
    // Table loads in mid-frame do not move the raster position.
    send_table_write(CH_W'(1), TABLE_BITS'($urandom), 16'($urandom));
    send_table_write(CH_W'(3), TABLE_BITS'($urandom), 16'($urandom));
    repeat (52) send_sample();
  endtask

  // Every register reads back what was written, trimmed to its width.
  task automatic test_register_readback();
    logic [APB_DW-1:0] rd, want;
    reg_idx_e ri;
    drain_results();
    for (int k = 0; k < 6; k++) begin
      ri = reg_idx_e'(k);
      write_reg(ri, $urandom);
    end
    for (int k = 0; k < 6; k++) begin
      ri = reg_idx_e'(k);
      read_reg(ri, rd);
      case (ri)
        REG_CHANNEL_ENABLE:  want = APB_DW'(cfg_enable);
        REG_FRAME_WIDTH:     want = APB_DW'(cfg_width);
        REG_FRAME_HEIGHT:    want = APB_DW'(cfg_height);
        REG_SKIP_TOP:        want = APB_DW'(cfg_skip_top);
        REG_SKIP_BOTTOM:     want = APB_DW'(cfg_skip_bottom);
        default:             want = APB_DW'(cfg_flyback);
      endcase
      if (rd !== want) begin
        note_mismatch($sformatf("register %s: expected %h, read %h", ri.name(), want, rd));
      end
    end
  endtask

  // The result side holds off while the input keeps coming.
  task automatic test_backpressure();
    set_config(4'b0101, 11'd8, 11'd8, '0, '0, 1'b0);
    gaps_on  = 1'b0;
    stalls_on = 1'b0;
    hold_req = 80;
    repeat (40) send_sample();
    gaps_on  = 1'b1;
    stalls_on = 1'b1;
  endtask

  // A line beyond the maximum width, then a frame beyond the maximum height
  // whose bottom band leaves only its first line.
  task automatic test_large_frames();
    set_config(4'b0110, 11'd2047, 11'd1, '0, '0, 1'b0);
    repeat (1030) send_sample();
    set_config(4'b1000, 11'd1, 11'd2047, 10'd0, 10'd1023, 1'b0);
    repeat (6) send_sample();
  endtask

  // Random phases: small frames, random registers, random table loads.
  task automatic test_random_traffic();
    int counted, n, r;
    logic [EN_W-1:0] en;
    logic [DIM_W-1:0] w, h;
    logic [SKIP_W-1:0] st, sb;
    counted = 0;
    while (counted < RANDOM_BEATS) begin
      en = EN_W'($urandom);
      r = $urandom_range(0, 99);
      w = (r < 8) ? '0 : (r < 90) ? DIM_W'($urandom_range(1, 6)) : DIM_W'($urandom_range(7, 20));
      r = $urandom_range(0, 99);
      h = (r < 8) ? '0 : (r < 90) ? DIM_W'($urandom_range(1, 6)) : DIM_W'($urandom_range(7, 20));
      st = ($urandom_range(0, 99) < 4) ? 10'd1023 : SKIP_W'($urandom_range(0, 2));
      sb = ($urandom_range(0, 99) < 4) ? 10'd1023 : SKIP_W'($urandom_range(0, 2));
      set_config(en, w, h, st, sb, 1'($urandom));
      gaps_on  = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(8, 90);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 99) < 12) begin
          send_table_write(CH_W'($urandom), TABLE_BITS'($urandom), 16'($urandom));
        end else begin
          send_sample();
        end
      end
      if (en != '0) counted += n;
    end
    gaps_on  = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Result-side ready: a requested long hold, random stalls, or ready.
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 99) < 20) begin
      stall_left = idle_len() - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Pair every result beat with the oldest predicted pixel.
  always @(posedge clk_i) begin
    pixel_t got, want;
    if (rst_n && m_tvalid && m_tready) begin
      got.addr  = m_tdata[21:0];
      got.value = m_tdata[37:22];
      got.chan  = m_tdata[39:38];
      if (expected_pixels.size() == 0) begin
        note_mismatch($sformatf("unexpected pixel addr %h value %h chan %0d",
                                got.addr, got.value, got.chan));
      end else begin
        want = expected_pixels.pop_front();
        if (got.addr !== want.addr || got.value !== want.value || got.chan !== want.chan) begin
          note_mismatch($sformatf(
            "pixel mismatch: expected addr %h value %h chan %0d, got addr %h value %h chan %0d",
            want.addr, want.value, want.chan, got.addr, got.value, got.chan));
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_directed_cases();
    test_flyback_sets();
    test_register_readback();
    test_backpressure();
    test_large_frames();
    test_random_traffic();
    drain_results();
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
